// ----- src/rca_pkg.sv -----
// Shared constants and types for the range capacity admission block.
`timescale 1ns / 1ps
package rca_pkg;

    localparam int NUM_SEGMENTS = 256;
    localparam int LOAD_W       = 16;
    localparam int SEG_AW       = $clog2(NUM_SEGMENTS);
    localparam int IDX_W        = SEG_AW + 1;
    localparam int LANES        = 8;
    localparam int LANE_AW      = $clog2(LANES);
    localparam int ROWS         = NUM_SEGMENTS / LANES;
    localparam int ROW_AW       = $clog2(ROWS);

    localparam int S_TDATA_W    = ((2 * IDX_W + LOAD_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = 8;

    typedef logic [LOAD_W-1:0]             load_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic [ROW_AW-1:0]             row_addr_t;
    typedef logic [LANES-1:0][LOAD_W-1:0]  row_t;

endpackage

// ----- src/range_capacity_admission.sv -----
// Top level of the range capacity admission block.
//
// Requests arrive on the s_ stream: a half-open segment range and an amount.
// The block scans the segment loads of the range for their peak and admits
// the request when peak plus amount stays within the capacity register; an
// admitted request raises every segment of the range by the amount. Each
// request yields one result transaction on the m_ stream (bit 0: accepted).
// Loads sit in a 32-row memory of 8 segments per row; one row is read per
// cycle through a shared lane unit, once for the peak and once for the add.
// An empty range is accepted without a scan. s_tready is high only while
// no request is in work; it rises again in the cycle the result appears.
// The result sits in an output register, so a stalled receiver holds one
// result while the next request is taken; its completion then waits for
// the register to drain.
// Reset (aresetn low, synchronous) zeroes capacity and marks every row
// invalid, so all loads read as zero at once with no clearing pass.
// cfg_wr_en writes cfg_wr_data into capacity; the user must write it only
// while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module range_capacity_admission (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rca_pkg::LOAD_W-1:0]      cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [8:0] range_start, [17:9] range_end, [33:18] amount, rest zero
    input  logic [rca_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] accepted, rest zero
    output logic [rca_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rca_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CHECK = 5'b00100,
        S_UPD   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam idx_t NUM_IDX = IDX_W'(NUM_SEGMENTS);

    state_t    state_reg;
    load_t     cap_reg;
    idx_t      lo_reg;
    idx_t      hi_reg;
    load_t     amt_reg;
    row_addr_t row_reg;
    row_addr_t first_row_reg;
    row_addr_t last_row_reg;
    logic      issue_reg;
    logic      pend_reg;
    row_addr_t tag_reg;
    load_t     peak_reg;
    logic      acc_reg;
    logic      m_tvalid_reg;
    logic      m_acc_reg;

    row_t              mem [ROWS];
    row_t              rd_data_reg;
    logic              rd_vld_reg;
    logic [ROWS-1:0]   row_vld_reg;

    idx_t      in_lo;
    idx_t      in_hi;
    idx_t      hi_m1;
    row_t      row_eff;
    load_t     row_max;
    row_t      row_sum;
    logic      wr_en;
    logic      over;
    logic      out_free;

    assign in_lo   = (s_tdata[IDX_W-1:0] > NUM_IDX) ? NUM_IDX : s_tdata[IDX_W-1:0];
    assign in_hi   = (s_tdata[2*IDX_W-1:IDX_W] > NUM_IDX) ? NUM_IDX
                                                          : s_tdata[2*IDX_W-1:IDX_W];
    assign hi_m1   = in_hi - IDX_W'(1);
    assign row_eff = rd_vld_reg ? rd_data_reg : '0;
    assign wr_en   = (state_reg == S_UPD) && pend_reg;
    assign over    = ({1'b0, peak_reg} + {1'b0, amt_reg}) > {1'b0, cap_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, m_acc_reg};

    rca_row_unit u_row (
        .row_data (row_eff),
        .row_addr (tag_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .amount   (amt_reg),
        .row_max  (row_max),
        .row_sum  (row_sum)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tag_reg] <= row_sum;
        end
        rd_data_reg <= mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= row_vld_reg[row_reg];
            if (wr_en) begin
                row_vld_reg[tag_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            row_reg      <= '0;
        end else begin
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        lo_reg   <= in_lo;
                        hi_reg   <= in_hi;
                        amt_reg  <= s_tdata[2*IDX_W+LOAD_W-1:2*IDX_W];
                        peak_reg <= '0;
                        pend_reg <= 1'b0;
                        if (in_lo >= in_hi) begin
                            acc_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end else begin
                            row_reg       <= in_lo[SEG_AW-1:LANE_AW];
                            first_row_reg <= in_lo[SEG_AW-1:LANE_AW];
                            last_row_reg  <= hi_m1[SEG_AW-1:LANE_AW];
                            issue_reg     <= 1'b1;
                            state_reg     <= S_SCAN;
                        end
                    end
                end
                S_SCAN, S_UPD: begin
                    pend_reg <= issue_reg;
                    tag_reg  <= row_reg;
                    if (issue_reg) begin
                        if (row_reg == last_row_reg) begin
                            issue_reg <= 1'b0;
                        end else begin
                            row_reg <= row_reg + ROW_AW'(1);
                        end
                    end
                    if (pend_reg && state_reg == S_SCAN && row_max > peak_reg) begin
                        peak_reg <= row_max;
                    end
                    if (!issue_reg && !pend_reg) begin
                        if (state_reg == S_SCAN) begin
                            state_reg <= S_CHECK;
                        end else begin
                            acc_reg   <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CHECK: begin
                    if (over) begin
                        acc_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end else begin
                        row_reg   <= first_row_reg;
                        issue_reg <= 1'b1;
                        state_reg <= S_UPD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_acc_reg <= acc_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/rca_row_unit.sv -----
// Lane unit: masked peak and masked add over one row of segment loads.
`timescale 1ns / 1ps
module rca_row_unit (
    input  rca_pkg::row_t      row_data,
    input  rca_pkg::row_addr_t row_addr,
    input  rca_pkg::idx_t      lo,
    input  rca_pkg::idx_t      hi,
    input  rca_pkg::load_t     amount,
    output rca_pkg::load_t     row_max,
    output rca_pkg::row_t      row_sum
);
    import rca_pkg::*;

    always_comb begin
        idx_t  g;
        load_t m;
        m = '0;
        for (int k = 0; k < LANES; k++) begin
            g = IDX_W'({row_addr, LANE_AW'(k)});
            if (g >= lo && g < hi) begin
                row_sum[k] = row_data[k] + amount;
                if (row_data[k] > m) begin
                    m = row_data[k];
                end
            end else begin
                row_sum[k] = row_data[k];
            end
        end
        row_max = m;
    end

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for range_capacity_admission: directed rows around random phases.
`timescale 1ns / 1ps
module tb_top;
    import rca_pkg::*;

    typedef enum bit {REJECTED = 1'b0, ADMITTED = 1'b1} verdict_t;
    typedef enum bit {ROW_REQ, ROW_CAP} row_kind_t;
    typedef enum bit {BY_MODEL, BY_TABLE} verdict_src_t;

    typedef struct packed {
        row_kind_t    kind;
        idx_t         first;
        idx_t         past;
        load_t        amount;     // capacity value on ROW_CAP rows
        verdict_src_t src;
        verdict_t     verdict;
    } script_row_t;

    localparam int OPENING  = 22;
    localparam int SCRIPT_N = 30;
    localparam int PHASES   = 7;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LOAD_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    load_t    seg_load [NUM_SEGMENTS];
    load_t    capacity_now;
    verdict_t verdict_q [$];
    int       err_count = 0;
    bit       steady    = 1'b0;

    script_row_t script [SCRIPT_N] = '{
        '{ROW_REQ, 9'd0,   9'd256, 16'd0,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd256, 16'd1,     BY_TABLE, REJECTED},
        '{ROW_REQ, 9'd5,   9'd5,   16'd65535, BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd511, 9'd511, 16'd7,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd300, 9'd0,   16'd65535, BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd1,   16'd0,     BY_TABLE, ADMITTED},
        '{ROW_CAP, 9'd0,   9'd0,   16'd65535, BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd256, 16'd1,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd2,   16'd65535, BY_TABLE, REJECTED},
        '{ROW_REQ, 9'd255, 9'd511, 16'd3,     BY_TABLE, ADMITTED},
        '{ROW_CAP, 9'd0,   9'd0,   16'd20,    BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd10,  9'd40,  16'd19,    BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd39,  9'd41,  16'd1,     BY_TABLE, REJECTED},
        '{ROW_REQ, 9'd40,  9'd41,  16'd19,    BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd256, 16'd0,     BY_TABLE, ADMITTED},
        '{ROW_CAP, 9'd0,   9'd0,   16'd3,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd10,  9'd11,  16'd0,     BY_TABLE, REJECTED},
        '{ROW_REQ, 9'd0,   9'd1,   16'd2,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd41,  9'd43,  16'd1,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd20,  9'd20,  16'd0,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd256, 9'd300, 16'd9,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd1,   9'd0,   16'd0,     BY_TABLE, ADMITTED},
        // closing rows, run after the random phases
        '{ROW_CAP, 9'd0,   9'd0,   16'd65535, BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd256, 16'd0,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd256, 16'd65535, BY_MODEL, REJECTED},
        '{ROW_REQ, 9'd128, 9'd129, 16'd65535, BY_MODEL, REJECTED},
        '{ROW_CAP, 9'd0,   9'd0,   16'd0,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd0,   9'd256, 16'd0,     BY_MODEL, REJECTED},
        '{ROW_REQ, 9'd3,   9'd3,   16'd0,     BY_TABLE, ADMITTED},
        '{ROW_REQ, 9'd511, 9'd511, 16'd65535, BY_TABLE, ADMITTED}
    };

    int phase_cap [PHASES] = '{4000, 12000, 1, 25000, 65535, 300, 65535};

    range_capacity_admission dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic verdict_t admit_request(idx_t first, idx_t past, load_t amt);
        int lo;
        int hi;
        int peak;
        lo = (first > NUM_SEGMENTS) ? NUM_SEGMENTS : int'(first);
        hi = (past > NUM_SEGMENTS) ? NUM_SEGMENTS : int'(past);
        if (lo >= hi) return ADMITTED;
        peak = 0;
        for (int i = lo; i < hi; i++) begin
            if (int'(seg_load[i]) > peak) peak = seg_load[i];
        end
        if (peak + int'(amt) > int'(capacity_now)) return REJECTED;
        for (int i = lo; i < hi; i++) seg_load[i] = seg_load[i] + amt;
        return ADMITTED;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue(idx_t first, idx_t past, load_t amt, verdict_src_t src,
                         verdict_t fixed);
        int gap;
        verdict_t want;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({amt, past, first});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = admit_request(first, past, amt);
        verdict_q.insert(verdict_q.size(), (src == BY_TABLE) ? fixed : want);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
    endtask

    task automatic set_capacity(load_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        capacity_now = value;
    endtask

    task automatic walk(int from_row, int to_row);
        for (int i = from_row; i < to_row; i++) begin
            if (script[i].kind == ROW_CAP) begin
                drain();
                set_capacity(script[i].amount);
            end else begin
                issue(script[i].first, script[i].past, script[i].amount,
                      script[i].src, script[i].verdict);
            end
        end
    endtask

    task automatic rand_request();
        idx_t  first;
        idx_t  past;
        load_t amt;
        int    r;
        int    width;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            first = idx_t'($urandom_range(0, 511));
            past  = idx_t'($urandom_range(0, first));
        end else if (r < 14) begin
            first = idx_t'($urandom_range(200, 511));
            past  = idx_t'($urandom_range(257, 511));
        end else if (r < 20) begin
            first = '0;
            past  = idx_t'($urandom_range(256, 511));
        end else begin
            first = idx_t'($urandom_range(0, 255));
            width = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 16)
                                               : $urandom_range(1, 256);
            past  = idx_t'(int'(first) + width);
        end
        r = $urandom_range(0, 99);
        if (r < 10)      amt = '0;
        else if (r < 22) amt = load_t'($urandom_range(0, 65535));
        else             amt = load_t'($urandom_range(0, capacity_now / 48 + 2));
        issue(first, past, amt, BY_MODEL, REJECTED);
    endtask

    // result transactions
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected result, m_tdata=%h", $time, m_tdata);
            end else begin
                if (m_tdata !== M_TDATA_W'(verdict_q[0])) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: accepted mismatch, expected %0d got m_tdata=%h",
                                 $time, verdict_q[0], m_tdata);
                end
                void'(verdict_q.pop_front());
            end
        end
    end

    initial begin
        int burst;
        int gap;
        wait (aresetn);
        forever begin
            if (steady) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
                m_tready <= 1'b1;
                repeat (burst) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_SEGMENTS; i++) seg_load[i] = '0;
        capacity_now = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        walk(0, OPENING);
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_capacity(load_t'(phase_cap[p]));
            steady = (p == 2 || p == 5);
            repeat (150) rand_request();
        end
        steady = 1'b0;
        walk(OPENING, SCRIPT_N);

        drain();
        repeat (80) @(posedge aclk);
        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
